// File: hw/rtl/ddlc_pkg.sv
// Shared types and constants for the dawn/dusk lamp controller.
// No dependencies; imported by every module of the block.
package ddlc_pkg;

    // Day/night phase, low two bits of the phase register
    localparam logic [1:0] PH_DAY         = 2'd0;
    localparam logic [1:0] PH_DEEP_NIGHT  = 2'd1;
    localparam logic [1:0] PH_EARLY_DAY   = 2'd2;
    localparam logic [1:0] PH_EARLY_NIGHT = 2'd3;

    // Event codes reported in event_res
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DAWN = 2'd1;
    localparam logic [1:0] EV_DUSK = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LUM_SWITCH  = 2'd0;
    localparam logic [1:0] REG_LUM_DAWN    = 2'd1;
    localparam logic [1:0] REG_OFF_OFFSET  = 2'd2;
    localparam logic [1:0] REG_MIDNIGHT_CR = 2'd3;

    // Configuration reset values
    localparam logic [9:0]  LUM_SWITCH_RST = 10'd512;
    localparam logic [9:0]  LUM_DAWN_RST   = 10'd512;
    localparam logic [16:0] OFF_OFFSET_RST = 17'h1F1F0;  // -3600 s
    localparam logic [14:0] MIDNIGHT_RST   = 15'd0;

    // Time constants in seconds
    localparam logic [31:0] DAY_SEC      = 32'd86400;
    localparam logic [31:0] HALF_DAY_SEC = 32'd43200;
    localparam logic [31:0] LAMP_MAX_SEC = 32'd14400;
    localparam logic [31:0] DAYLIGHT_RST = 32'd43200;

    // Luminance scaling
    localparam logic [9:0]  LUM_DAY_BASE = 10'h200;
    localparam logic [14:0] PCT_SCALE    = 15'd25;
    localparam logic [14:0] PCT_ROUND    = 15'h80;

    typedef struct packed {
        logic [9:0]  lum_switch;
        logic [9:0]  lum_dawn;
        logic [16:0] off_offset;
        logic [14:0] midnight_corr;
    } cfg_t;

    // One sample after preprocessing, with the time terms the state update needs
    typedef struct packed {
        logic        sampled;
        logic        time_zero;
        logic [31:0] time_sec;
        logic [9:0]  luminance;
        logic [6:0]  lum_percent;
        logic [31:0] lamp_max_end;   // time + 4 h
        logic [31:0] day_base;       // 86400 - time
        logic [31:0] midnight_base;  // time + 43200 + correction
    } item_t;

    // Result word, sampled in the lowest bit
    typedef struct packed {
        logic [6:0] lum_percent;
        logic       lamp_on_cmd;
        logic       lamp_off_cmd;
        logic [1:0] event_res;
        logic       sampled;
    } res_t;

endpackage

// File: hw/rtl/ddlc_prep.sv
// Input register and sample preprocessing pipeline: period check, percent scaling
// and time terms that do not depend on controller state. Uses ddlc_pkg.
module ddlc_prep import ddlc_pkg::*; #(
    parameter int SAMPLE_PERIOD = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_time,
    input  logic [9:0]  in_lum,
    input  logic [14:0] midnight_corr,
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);

    // time mod P is folded from byte residues into 16 bits, then a reciprocal
    // multiply gives the quotient of the folded value
    localparam int RecipShift = 22;
    localparam longint Recip  = ((64'sd1 <<< RecipShift) + SAMPLE_PERIOD - 1) / SAMPLE_PERIOD;
    localparam logic [22:0] RecipW  = 23'(Recip);
    localparam logic [21:0] PeriodW = 22'(SAMPLE_PERIOD);
    localparam logic [5:0]  Res0 = 6'(1 % SAMPLE_PERIOD);
    localparam logic [5:0]  Res1 = 6'(256 % SAMPLE_PERIOD);
    localparam logic [5:0]  Res2 = 6'(65536 % SAMPLE_PERIOD);
    localparam logic [5:0]  Res3 = 6'(16777216 % SAMPLE_PERIOD);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    logic [31:0] time1_reg;
    logic [9:0]  lum1_reg;
    item_t       item2_reg, item2_next, item3_reg, item4_reg, item4_next;
    logic [15:0] fold2_reg, fold2_next, fold3_reg;
    logic [15:0] quo3_reg, quo3_next;
    logic [38:0] quo_prod;
    logic [14:0] pct_prod;
    logic [21:0] back_prod;

    assign rdy4     = !v4_reg || item_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        pct_prod = 15'(lum1_reg) * PCT_SCALE + PCT_ROUND;
        fold2_next = 16'(16'(time1_reg[7:0]) * 16'(Res0))
                   + 16'(16'(time1_reg[15:8]) * 16'(Res1))
                   + 16'(16'(time1_reg[23:16]) * 16'(Res2))
                   + 16'(16'(time1_reg[31:24]) * 16'(Res3));
        item2_next.sampled       = 1'b0;
        item2_next.time_zero     = (time1_reg == 32'd0);
        item2_next.time_sec      = time1_reg;
        item2_next.luminance     = lum1_reg;
        item2_next.lum_percent   = pct_prod[14:8];
        item2_next.lamp_max_end  = time1_reg + LAMP_MAX_SEC;
        item2_next.day_base      = DAY_SEC - time1_reg;
        item2_next.midnight_base = time1_reg + HALF_DAY_SEC
                                 + {{17{midnight_corr[14]}}, midnight_corr};
    end

    assign quo_prod  = 39'(fold2_reg) * 39'(RecipW);
    assign quo3_next = 16'(quo_prod >> RecipShift);
    assign back_prod = 22'(quo3_reg) * PeriodW;

    always_comb begin
        item4_next         = item3_reg;
        item4_next.sampled = (22'(fold3_reg) == back_prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            time1_reg <= in_time;
            lum1_reg  <= in_lum;
        end
        if (rdy2) begin
            item2_reg <= item2_next;
            fold2_reg <= fold2_next;
        end
        if (rdy3) begin
            item3_reg <= item2_reg;
            fold3_reg <= fold2_reg;
            quo3_reg  <= quo3_next;
        end
        if (rdy4) item4_reg <= item4_next;
    end

    assign item_valid = v4_reg;
    assign item       = item4_reg;

endmodule

// File: hw/rtl/ddlc_core.sv
// Day/night state machine, lamp control and the result register.
// Uses ddlc_pkg; fed by ddlc_prep.
module ddlc_core import ddlc_pkg::*; #(
    parameter int DETECT_RUN = 6
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam logic [2:0] DetectRun = 3'(DETECT_RUN);

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] off_time_reg, off_time_next;
    logic [31:0] daylight_reg, daylight_next;
    logic [31:0] midnight_reg, midnight_next;
    logic [31:0] dusk_reg, dusk_next;
    logic        res_valid_reg;
    res_t        res_reg, res_next;

    logic        fire;
    logic        lamp;
    logic [1:0]  ph;
    logic [1:0]  ev;
    logic        off_cmd, on_cmd;
    logic [2:0]  count_inc;
    logic [9:0]  night_lvl, day_lvl;
    logic [31:0] off_diff;
    logic        expired;
    logic [31:0] daylight_new, midnight_new, off_cand;

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;

    assign count_inc = (count_reg == 3'd7) ? 3'd7 : count_reg + 3'd1;
    assign night_lvl = {1'b0, cfg.lum_dawn[9:1]};
    assign day_lvl   = LUM_DAY_BASE + night_lvl;
    assign off_diff  = off_time_reg - item.time_sec;
    assign expired   = off_diff[31] || (off_diff == 32'd0);

    assign daylight_new = (dusk_reg != 32'd0) ? dusk_reg + item.day_base : daylight_reg;
    assign midnight_new = item.midnight_base + (daylight_new >> 1);
    assign off_cand     = (midnight_reg != 32'd0)
                        ? midnight_reg + {{15{cfg.off_offset[16]}}, cfg.off_offset}
                        : item.lamp_max_end;

    always_comb begin
        count_next    = count_reg;
        off_time_next = off_time_reg;
        daylight_next = daylight_reg;
        midnight_next = midnight_reg;
        dusk_next     = dusk_reg;
        ev            = EV_NONE;
        off_cmd       = 1'b0;
        on_cmd        = 1'b0;
        lamp          = phase_reg[2];
        ph            = phase_reg[1:0];

        // off time reached: drop the lamp first
        if (phase_reg[2] && expired) begin
            lamp    = 1'b0;
            off_cmd = 1'b1;
        end

        case (phase_reg[1:0])
            PH_DEEP_NIGHT: begin
                if (item.luminance < cfg.lum_dawn) begin
                    count_next = 3'd0;
                end else if (count_inc < DetectRun) begin
                    count_next = count_inc;
                end else begin
                    daylight_next = daylight_new;
                    midnight_next = midnight_new;
                    count_next    = 3'd0;
                    if (lamp) off_cmd = 1'b1;
                    lamp = 1'b0;
                    ph   = PH_EARLY_DAY;
                    ev   = EV_DAWN;
                end
            end
            PH_EARLY_DAY: begin
                if (item.luminance < day_lvl) begin
                    count_next = 3'd0;
                end else begin
                    count_next = count_inc;
                    if (count_inc >= DetectRun) ph = PH_DAY;
                end
            end
            PH_DAY: begin
                if (lamp) begin
                    if (item.luminance >= cfg.lum_switch) begin
                        lamp    = 1'b0;
                        off_cmd = 1'b1;
                    end
                end else if (item.luminance < cfg.lum_switch) begin
                    lamp          = 1'b1;
                    on_cmd        = 1'b1;
                    off_time_next = off_cand;
                end
                // a dark sample at time zero counts as dusk at once
                if (item.luminance >= cfg.lum_dawn) begin
                    count_next = 3'd0;
                end else if (count_inc < DetectRun && !item.time_zero) begin
                    count_next = count_inc;
                end else begin
                    dusk_next  = item.time_sec;
                    count_next = 3'd0;
                    ph         = PH_EARLY_NIGHT;
                    ev         = EV_DUSK;
                end
            end
            PH_EARLY_NIGHT: begin
                if (item.luminance > night_lvl) begin
                    count_next = 3'd0;
                end else begin
                    count_next = count_inc;
                    if (count_inc >= DetectRun) ph = PH_DEEP_NIGHT;
                end
            end
            default: begin
                ph = phase_reg[1:0];
            end
        endcase

        phase_next = {lamp, ph};

        if (item.sampled) begin
            res_next.sampled      = 1'b1;
            res_next.event_res    = ev;
            res_next.lamp_off_cmd = off_cmd;
            res_next.lamp_on_cmd  = on_cmd;
            res_next.lum_percent  = item.lum_percent;
        end else begin
            res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            phase_reg     <= {1'b0, PH_DAY};
            count_reg     <= 3'd0;
            off_time_reg  <= 32'd0;
            daylight_reg  <= DAYLIGHT_RST;
            midnight_reg  <= 32'd0;
            dusk_reg      <= 32'd0;
        end else begin
            if (item_ready) res_valid_reg <= item_valid;
            // unsampled ticks leave the state alone
            if (fire && item.sampled) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                off_time_reg <= off_time_next;
                daylight_reg <= daylight_next;
                midnight_reg <= midnight_next;
                dusk_reg     <= dusk_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/dawn_dusk_lamp_controller_unit.sv
// Dawn/dusk lamp controller top level: stream ports, APB register file,
// preprocessing pipeline (ddlc_prep) and state update (ddlc_core). Uses ddlc_pkg.
// An accepted input transaction passes the ddlc_prep stages and the result register to m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls; combinational state update.
// Reset: aresetn synchronous, active low; clears pipeline valids, day/night state
// and configuration registers to their defaults.
module dawn_dusk_lamp_controller_unit import ddlc_pkg::*; #(
    parameter int DETECT_RUN    = 6,
    parameter int SAMPLE_PERIOD = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] time_sec, [41:32] luminance, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] sampled, [2:1] event_res, [3] lamp_off_cmd,
                                   // [4] lamp_on_cmd, [11:5] lum_percent, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;
    logic        item_valid, item_ready;
    item_t       item;
    res_t        res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lum_switch    <= LUM_SWITCH_RST;
            cfg_reg.lum_dawn      <= LUM_DAWN_RST;
            cfg_reg.off_offset    <= OFF_OFFSET_RST;
            cfg_reg.midnight_corr <= MIDNIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LUM_SWITCH:  cfg_reg.lum_switch    <= pwdata[9:0];
                REG_LUM_DAWN:    cfg_reg.lum_dawn      <= pwdata[9:0];
                REG_OFF_OFFSET:  cfg_reg.off_offset    <= pwdata[16:0];
                REG_MIDNIGHT_CR: cfg_reg.midnight_corr <= pwdata[14:0];
                default:         cfg_reg.lum_switch    <= cfg_reg.lum_switch;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LUM_SWITCH:  prdata = {22'd0, cfg_reg.lum_switch};
            REG_LUM_DAWN:    prdata = {22'd0, cfg_reg.lum_dawn};
            REG_OFF_OFFSET:  prdata = {{15{cfg_reg.off_offset[16]}}, cfg_reg.off_offset};
            REG_MIDNIGHT_CR: prdata = {{17{cfg_reg.midnight_corr[14]}},
                                       cfg_reg.midnight_corr};
            default:         prdata = 32'd0;
        endcase
    end

    ddlc_prep #(
        .SAMPLE_PERIOD (SAMPLE_PERIOD)
    ) u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_time       (s_tdata[31:0]),
        .in_lum        (s_tdata[41:32]),
        .midnight_corr (cfg_reg.midnight_corr),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    ddlc_core #(
        .DETECT_RUN (DETECT_RUN)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {4'd0, res};

endmodule

// File: hw/rtl/ddlc_checker.sv
// Port-level checks for the dawn/dusk lamp controller, bound to the top level.
// Uses ddlc_pkg for event codes.
module ddlc_checker import ddlc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_unsampled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[15:1] == 15'd0)
        else $error("unsampled result carries nonzero fields");

    a_no_on_at_dawn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[2:1] != EV_DAWN)
        else $error("lamp on command together with dawn");

endmodule

bind dawn_dusk_lamp_controller_unit ddlc_checker u_ddlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
